@@ hdl/vacd_pkg.sv @@
// Package for the voice activity command detector.
// Holds the command and register-index codes, reset values and the result type.
// No dependencies; imported by the top level and the checker.
package vacd_pkg;

  localparam int unsigned HistoryDepthDefault = 8;

  localparam int unsigned VolW  = 11;
  localparam int unsigned DurW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SylW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [VolW-1:0]  ActiveLevelRst  = VolW'(288);
  localparam logic [VolW-1:0]  SilenceLevelRst = VolW'(128);
  localparam logic [DurW-1:0]  GapMinRst       = DurW'(150);
  localparam logic [DurW-1:0]  GapMaxRst       = DurW'(450);
  localparam logic [DurW-1:0]  MinBurstRst     = DurW'(60);
  localparam logic [DurW-1:0]  LongBurstRst    = DurW'(500);
  localparam logic [DurW-1:0]  WakeHoldRst     = DurW'(6000);
  localparam logic [SylW-1:0]  SylMax          = {SylW{1'b1}};

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_WAKEUP  = 2'd1,
    CMD_HAPPY   = 2'd2,
    CMD_FORWARD = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_LEVEL  = 3'd0,
    REG_SILENCE_LEVEL = 3'd1,
    REG_GAP_MIN       = 3'd2,
    REG_GAP_MAX       = 3'd3,
    REG_MIN_BURST     = 3'd4,
    REG_LONG_BURST    = 3'd5,
    REG_WAKE_HOLD     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    cmd_e command;
    logic awake;
    logic speaking;
  } result_t;

endpackage

@@ hdl/voice_activity_command_detector_top.sv @@
// Voice activity command detector, top level.
// Each result is registered. The history sum is a running sum kept in a register.
// Throughput: one request per cycle unless stalled; a two-entry output buffer keeps
// the input open while one result waits.
// Reset: registers return to their defaults, history reads as zero until the ring
// has wrapped once, all burst and wake state is cleared. No clearing pass.
module voice_activity_command_detector_top
  import vacd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VolW-1:0]     frame_volume_i,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          command_o,
  output logic                awake_o,
  output logic                speaking_o
);

  localparam int unsigned SlotW = $clog2(HISTORY_DEPTH);
  localparam int unsigned SumW  = VolW + SlotW;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(HISTORY_DEPTH - 1);

  // Configuration registers
  logic [VolW-1:0] active_level_q, silence_level_q;
  logic [DurW-1:0] gap_min_q, gap_max_q, min_burst_q, long_burst_q, wake_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q  <= ActiveLevelRst;
      silence_level_q <= SilenceLevelRst;
      gap_min_q       <= GapMinRst;
      gap_max_q       <= GapMaxRst;
      min_burst_q     <= MinBurstRst;
      long_burst_q    <= LongBurstRst;
      wake_hold_q     <= WakeHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ACTIVE_LEVEL:  active_level_q  <= cfg_wdata_i[VolW-1:0];
        REG_SILENCE_LEVEL: silence_level_q <= cfg_wdata_i[VolW-1:0];
        REG_GAP_MIN:       gap_min_q       <= cfg_wdata_i;
        REG_GAP_MAX:       gap_max_q       <= cfg_wdata_i;
        REG_MIN_BURST:     min_burst_q     <= cfg_wdata_i;
        REG_LONG_BURST:    long_burst_q    <= cfg_wdata_i;
        REG_WAKE_HOLD:     wake_hold_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake
  logic    accept;
  logic    out_fire;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Volume history ring with running sum
  logic [VolW-1:0]  hist_mem [HISTORY_DEPTH];
  logic [VolW-1:0]  rd_data_q;
  logic [SlotW-1:0] slot_q, slot_d, rd_addr;
  logic             filled_q, filled_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [VolW-1:0]  old_vol;

  always_comb begin
    slot_d   = slot_q;
    filled_d = filled_q;
    if (accept) begin
      if (slot_q == SlotLast) begin
        slot_d   = '0;
        filled_d = 1'b1;
      end else begin
        slot_d = slot_q + SlotW'(1);
      end
    end
  end

  // The entry at the current slot only holds data once the ring has wrapped.
  assign old_vol = filled_q ? rd_data_q : '0;
  assign sum_d   = sum_q - SumW'(old_vol) + SumW'(frame_volume_i);
  assign rd_addr = slot_d;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[slot_q] <= frame_volume_i;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  // Burst and wake state
  logic             in_burst_q, in_burst_d;
  logic             awake_q, awake_d;
  logic [TimeW-1:0] burst_start_q, burst_start_d;
  logic [TimeW-1:0] last_end_q, last_end_d;
  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [SylW-1:0]  syl_q, syl_d;
  cmd_e             cmd;

  logic [SumW-1:0]  active_thr, silence_thr;
  logic [TimeW-1:0] gap, dur;
  logic             above, below, awake_live, gap_ok, dur_ok;

  assign active_thr  = SumW'(active_level_q) * SumW'(HISTORY_DEPTH);
  assign silence_thr = SumW'(silence_level_q) * SumW'(HISTORY_DEPTH);
  assign above       = sum_d > active_thr;
  assign below       = sum_d < silence_thr;
  assign gap         = now_ms_i - last_end_q;
  assign dur         = now_ms_i - burst_start_q;
  assign gap_ok      = (gap >= TimeW'(gap_min_q)) && (gap <= TimeW'(gap_max_q));
  assign dur_ok      = dur >= TimeW'(min_burst_q);
  // Deadline compare is plain unsigned and ignores wrap.
  assign awake_live  = awake_q && !(now_ms_i > deadline_q);

  always_comb begin
    in_burst_d    = in_burst_q;
    awake_d       = awake_live;
    burst_start_d = burst_start_q;
    last_end_d    = last_end_q;
    deadline_d    = deadline_q;
    syl_d         = syl_q;
    cmd           = CMD_NONE;
    if (above) begin
      if (!in_burst_q) begin
        in_burst_d    = 1'b1;
        burst_start_d = now_ms_i;
        if (gap_ok) begin
          if (syl_q != SylMax) begin
            syl_d = syl_q + SylW'(1);
          end
        end else begin
          syl_d = SylW'(1);
        end
      end
    end else if (in_burst_q && below) begin
      in_burst_d = 1'b0;
      last_end_d = now_ms_i;
      if (dur_ok) begin
        deadline_d = now_ms_i + TimeW'(wake_hold_q);
        if (!awake_live) begin
          awake_d = 1'b1;
          cmd     = CMD_WAKEUP;
        end else if (syl_q >= SylW'(2)) begin
          cmd   = CMD_HAPPY;
          syl_d = '0;
        end else if (dur >= TimeW'(long_burst_q)) begin
          cmd = CMD_FORWARD;
        end
      end
    end
  end

  assign res.command  = cmd;
  assign res.awake    = awake_d;
  assign res.speaking = in_burst_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q        <= '0;
      filled_q      <= 1'b0;
      sum_q         <= '0;
      in_burst_q    <= 1'b0;
      awake_q       <= 1'b0;
      burst_start_q <= '0;
      last_end_q    <= '0;
      deadline_q    <= '0;
      syl_q         <= '0;
    end else if (accept) begin
      slot_q        <= slot_d;
      filled_q      <= filled_d;
      sum_q         <= sum_d;
      in_burst_q    <= in_burst_d;
      awake_q       <= awake_d;
      burst_start_q <= burst_start_d;
      last_end_q    <= last_end_d;
      deadline_q    <= deadline_d;
      syl_q         <= syl_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = out_q.command;
  assign awake_o     = out_q.awake;
  assign speaking_o  = out_q.speaking;

endmodule

@@ hdl/vacd_chk.sv @@
// Port-level checker for the voice activity command detector.
// Depends on vacd_pkg; bound to voice_activity_command_detector_top below.
module vacd_chk
  import vacd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          command_o,
  input logic                awake_o,
  input logic                speaking_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o)
      && $stable(awake_o) && $stable(speaking_o))
    else $error("stalled result changed");

  // Input can only be held off while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A wakeup always leaves the block awake.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_WAKEUP |-> awake_o)
    else $error("wakeup without awake");

  // Any command comes from a burst end, so speech is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o != CMD_NONE |-> !speaking_o)
    else $error("command while speaking");

endmodule

bind voice_activity_command_detector_top vacd_chk u_vacd_chk (.*);
